/* rtl/isort_pkg.sv */
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // Input word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } item_t;

  // Output word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } result_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                         valid;
    logic                         greater;  // holds an entry above the key
    logic signed [DATA_WIDTH-1:0] value;
  } cell_link_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic                         insert;
    logic                         shift;    // drain: move one place toward cell 0
    logic signed [DATA_WIDTH-1:0] key;
  } cell_ctrl_t;

endpackage

/* rtl/isort_cell.sv */
// One cell of the sorting chain: holds one entry and its valid bit.
module isort_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  isort_pkg::cell_ctrl_t ctrl,
  input  isort_pkg::cell_link_t left,
  input  isort_pkg::cell_link_t right,
  output isort_pkg::cell_link_t link
);

  logic                                    valid;
  logic signed [isort_pkg::DATA_WIDTH-1:0] value;
  logic                                    greater;

  // strict compare keeps equal values in arrival order
  assign greater = valid && (ctrl.key < value);

  assign link.valid   = valid;
  assign link.greater = greater;
  assign link.value   = value;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end else if (ctrl.insert) begin
      valid <= valid | left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right.value;
    end else if (ctrl.insert) begin
      if (left.greater) begin
        value <= left.value;
      end else if (greater || (!valid && left.valid)) begin
        value <= ctrl.key;
      end
    end
  end

endmodule

/* rtl/insertion_sorter_unit.sv */
// Insertion sorter top level: a chain of sorting cells with a drain sequencer.
// Throughput: one input word per cycle while a set is being collected.
// After the word marked last is taken, the drain flag is set and cell 0 is then
// popped into the output register; the set drains at one result per cycle
// while the output is not stalled; input is stalled during the drain.
// Reset: synchronous, clears cell valid bits, the drop flag and the drain state.
module insertion_sorter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  isort_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output isort_pkg::result_t result
);

  localparam int N = isort_pkg::CAPACITY;

  isort_pkg::cell_ctrl_t ctrl;
  isort_pkg::cell_link_t links [N];
  isort_pkg::cell_link_t edge_left;
  isort_pkg::cell_link_t edge_right;
  logic [N-1:0]          cell_valid;

  logic draining;     // emitting the stored set
  logic dropped;      // a word was dropped in this set
  logic item_accept;
  logic full;
  logic step;         // pop cell 0 into the output register
  logic final_pop;    // cell 0 holds the last entry

  assign item_stall  = draining;
  assign item_accept = item_valid && !item_stall;
  assign full        = cell_valid[N-1];
  assign step        = draining && (!result_valid || !result_stall);
  assign final_pop   = !cell_valid[1];

  // Boundaries: left of cell 0 acts as an occupied slot below every key,
  // right of the last cell is always empty.
  assign edge_left.valid    = 1'b1;
  assign edge_left.greater  = 1'b0;
  assign edge_left.value    = '0;
  assign edge_right.valid   = 1'b0;
  assign edge_right.greater = 1'b0;
  assign edge_right.value   = '0;

  assign ctrl.insert = item_accept && !full;
  assign ctrl.shift  = step;
  assign ctrl.key    = item.value;

  for (genvar i = 0; i < N; i++) begin : g_cell
    isort_pkg::cell_link_t left_i;
    isort_pkg::cell_link_t right_i;

    if (i == 0) begin : g_first
      assign left_i = edge_left;
    end else begin : g_mid_l
      assign left_i = links[i-1];
    end

    if (i == N-1) begin : g_last
      assign right_i = edge_right;
    end else begin : g_mid_r
      assign right_i = links[i+1];
    end

    isort_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (left_i),
      .right (right_i),
      .link  (links[i])
    );

    assign cell_valid[i] = links[i].valid;
  end

  // Drain sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      draining     <= 1'b0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_accept) begin
        if (full) begin
          dropped <= 1'b1;
        end
        if (item.last) begin
          draining <= 1'b1;
        end
      end
      if (step) begin
        result_valid <= 1'b1;
        if (final_pop) begin
          draining <= 1'b0;
          dropped  <= 1'b0;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.sorted_value <= links[0].value;
      result.last_out     <= final_pop;
      result.overflow     <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    item_accept && item.last |=> draining)
    else $error("last word did not start the drain");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> cell_valid[0])
    else $error("draining with an empty chain");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    step && final_pop |=> !draining && !dropped)
    else $error("drain did not close the set");

  a_step_loads: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("popped entry not presented");
`endif

endmodule
